// ===== sv/veia_pkg.sv =====
// ----------------------------------------------------------------------------
// veia_pkg: shared types and constants of the vector integer element-wise ALU
// Operation codes, width codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package veia_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
        OP_SREM = 5'd4,  OP_UREM = 5'd5,  OP_MAX  = 5'd6,  OP_MIN  = 5'd7,
        OP_AND  = 5'd8,  OP_OR   = 5'd9,  OP_XOR  = 5'd10, OP_SHL  = 5'd11,
        OP_ASHR = 5'd12, OP_NOT  = 5'd13, OP_ABS  = 5'd14, OP_RELU = 5'd15,
        OP_EQ   = 5'd16, OP_NE   = 5'd17, OP_LT   = 5'd18, OP_GT   = 5'd19,
        OP_GE   = 5'd20, OP_LE   = 5'd21, OP_SEL  = 5'd22
    } op_t;

    // back-end sequencer states
    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} bst_t;

    localparam logic [1:0] EW_RESET = 2'd2;

    // classified item: operands sign-extended at the lane width
    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  ew;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] uc;
        logic [63:0] mask;
        logic        b_zero;
        logic        shamt_big;
        logic [5:0]  shamt;
    } item_t;

    function automatic logic [63:0] lane_mask(input logic [1:0] ew);
        unique case (ew)
            2'd0:    lane_mask = 64'h0000_0000_0000_00ff;
            2'd1:    lane_mask = 64'h0000_0000_0000_ffff;
            2'd2:    lane_mask = 64'h0000_0000_ffff_ffff;
            default: lane_mask = 64'hffff_ffff_ffff_ffff;
        endcase
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] x, input logic [1:0] ew);
        unique case (ew)
            2'd0:    sext = {{56{x[7]}}, x[7:0]};
            2'd1:    sext = {{48{x[15]}}, x[15:0]};
            2'd2:    sext = {{32{x[31]}}, x[31:0]};
            default: sext = x;
        endcase
    endfunction

endpackage

// ===== sv/veia_front.sv =====
// ----------------------------------------------------------------------------
// veia_front: accept and classify
// Reads operands at the element width and pushes a classified entry into the
// queue; ready follows queue space.
// ----------------------------------------------------------------------------
module veia_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [4:0]            s_kind,
    input  logic [63:0]           s_operand_a,
    input  logic [63:0]           s_operand_b,
    input  logic [63:0]           s_operand_c,
    output logic                  q_valid,
    input  logic                  q_ready,
    output veia_pkg::item_t       q_item
);
    import veia_pkg::*;

    localparam int QD = 2;

    logic [1:0]  ew_reg;
    item_t       mem_q [QD];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    item_t       cls;
    logic [63:0] m, ub;
    logic [6:0]  w;
    logic        push, pop;

    // hold the width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ew_reg <= EW_RESET;
        end else if (cfg_we) begin
            ew_reg <= cfg_wdata;
        end
    end

    // classify the incoming beat
    always_comb begin
        m  = lane_mask(ew_reg);
        ub = s_operand_b & m;
        w  = 7'd8 << ew_reg;
        cls.kind      = s_kind;
        cls.ew        = ew_reg;
        cls.sa        = sext(s_operand_a, ew_reg);
        cls.sb        = sext(s_operand_b, ew_reg);
        cls.uc        = s_operand_c & m;
        cls.mask      = m;
        cls.b_zero    = (ub == 64'd0);
        cls.shamt_big = (ub >= {57'd0, w});
        cls.shamt     = ub[5:0];
    end

    assign s_ready = (cnt_reg != 2'(QD));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem_q[rp_reg];

    // advance queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_q[wp_reg] <= cls;
        end
    end

endmodule

// ===== sv/veia_divider.sv =====
// ----------------------------------------------------------------------------
// veia_divider: iterative unsigned divider
// Restoring division, one quotient bit a cycle for all 64 quotient bits.
// ----------------------------------------------------------------------------
module veia_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    logic [63:0] q_reg, r_reg, d_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [64:0] trial;

    assign trial     = {r_reg, q_reg[63]} - {1'b0, d_reg};
    assign busy      = (cnt_reg != 7'd0);
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    // step one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 7'd1);
            if (start) begin
                cnt_reg <= 7'd64;
            end else if (busy) begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= 64'd0;
            d_reg <= divisor;
        end else if (busy) begin
            if (!trial[64]) begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= {r_reg[62:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/veia_back.sv =====
// ----------------------------------------------------------------------------
// veia_back: execute
// Simple ops go straight to the output register; multiply registers its
// 32-bit partial products and then sums them into the output register;
// divide and remainder use the iterative divider.
// ----------------------------------------------------------------------------
module veia_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  veia_pkg::item_t       q_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [63:0]           m_result
);
    import veia_pkg::*;

    bst_t        st_reg, st_next;
    item_t       it_reg;
    logic [63:0] res_reg, res_next;
    logic        vld_reg, vld_next;
    logic [63:0] pll_reg, plh_reg, phl_reg;
    logic [63:0] alu;
    logic        out_free, take, slow;
    logic        lt_ab, lt_ba, na, nb;
    logic [63:0] ua, ub, mag_a, mag_b, shl_v, sra_v;
    logic        dv_start, dv_busy, dv_done;
    logic [63:0] dv_n, dv_d, dv_q, dv_r, dv_res, mul_v;
    logic [4:0]  k;

    assign out_free = !vld_reg || m_ready;
    assign k        = q_item.kind;
    assign ua       = q_item.sa & q_item.mask;
    assign ub       = q_item.sb & q_item.mask;
    assign na       = q_item.sa[63];
    assign nb       = q_item.sb[63];
    assign lt_ab    = $signed(q_item.sa) < $signed(q_item.sb);
    assign lt_ba    = $signed(q_item.sb) < $signed(q_item.sa);
    assign mag_a    = na ? 64'd0 - q_item.sa : q_item.sa;
    assign mag_b    = nb ? 64'd0 - q_item.sb : q_item.sb;
    assign shl_v    = q_item.shamt_big ? 64'd0 : ua << q_item.shamt;
    assign sra_v    = q_item.shamt_big ? {64{na}} :
                      64'($signed(q_item.sa) >>> q_item.shamt);
    assign slow     = (k == OP_MUL) || (k == OP_DIV) || (k == OP_SREM) || (k == OP_UREM);

    // evaluate the simple ops
    always_comb begin
        case (k)
            OP_ADD:  alu = ua + ub;
            OP_SUB:  alu = ua - ub;
            OP_MAX:  alu = lt_ba ? q_item.sa : q_item.sb;
            OP_MIN:  alu = lt_ab ? q_item.sa : q_item.sb;
            OP_AND:  alu = ua & ub;
            OP_OR:   alu = ua | ub;
            OP_XOR:  alu = ua ^ ub;
            OP_SHL:  alu = shl_v;
            OP_ASHR: alu = sra_v;
            OP_NOT:  alu = ~ua;
            OP_ABS:  alu = mag_a;
            OP_RELU: alu = na ? 64'd0 : ua;
            OP_EQ:   alu = {63'd0, ua == ub};
            OP_NE:   alu = {63'd0, ua != ub};
            OP_LT:   alu = {63'd0, lt_ab};
            OP_GT:   alu = {63'd0, lt_ba};
            OP_GE:   alu = {63'd0, !lt_ab};
            OP_LE:   alu = {63'd0, !lt_ba};
            OP_SEL:  alu = (ua != 64'd0) ? ub : q_item.uc;
            default: alu = 64'd0;
        endcase
    end

    // divider operands come from the held item
    assign dv_n = (it_reg.kind == OP_UREM) ? (it_reg.sa & it_reg.mask) :
                  (it_reg.sa[63] ? 64'd0 - it_reg.sa : it_reg.sa);
    assign dv_d = (it_reg.kind == OP_UREM) ? (it_reg.sb & it_reg.mask) :
                  (it_reg.sb[63] ? 64'd0 - it_reg.sb : it_reg.sb);

    veia_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dv_start),
        .dividend  (dv_n),
        .divisor   (dv_d),
        .busy      (dv_busy),
        .done      (dv_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    // fix signs of the divider result; a zero divisor gives zero
    always_comb begin
        if (it_reg.b_zero) begin
            dv_res = 64'd0;
        end else if (it_reg.kind == OP_DIV) begin
            dv_res = (it_reg.sa[63] != it_reg.sb[63]) ? 64'd0 - dv_q : dv_q;
        end else if (it_reg.kind == OP_SREM) begin
            dv_res = it_reg.sa[63] ? 64'd0 - dv_r : dv_r;
        end else begin
            dv_res = dv_r;
        end
    end

    assign mul_v = pll_reg + {plh_reg[31:0], 32'd0} + {phl_reg[31:0], 32'd0};

    // sequence the slow ops and load the output register
    always_comb begin
        st_next  = st_reg;
        res_next = res_reg;
        vld_next = vld_reg && !m_ready;
        q_ready  = 1'b0;
        take     = 1'b0;
        dv_start = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (slow) begin
                        q_ready = 1'b1;
                        take    = 1'b1;
                        st_next = (k == OP_MUL) ? ST_MUL : ST_FIN;
                    end else if (out_free) begin
                        q_ready  = 1'b1;
                        res_next = alu & q_item.mask;
                        vld_next = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                dv_start = 1'b1;
                st_next  = ST_DIV;
            end
            ST_MUL: begin
                if (out_free) begin
                    res_next = mul_v & it_reg.mask;
                    vld_next = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
            ST_DIV: begin
                if ((dv_done || !dv_busy) && out_free && !dv_start) begin
                    if (!dv_busy) begin
                        res_next = dv_res & it_reg.mask;
                        vld_next = 1'b1;
                        st_next  = ST_IDLE;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            vld_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            vld_reg <= vld_next;
        end
    end

    // hold the item and the partial products
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (take) begin
            it_reg  <= q_item;
            pll_reg <= 64'(ua[31:0]) * 64'(ub[31:0]);
            plh_reg <= 64'(ua[31:0]) * 64'(ub[63:32]);
            phl_reg <= 64'(ua[63:32]) * 64'(ub[31:0]);
        end
    end

    assign m_valid  = vld_reg;
    assign m_result = res_reg;

endmodule

// ===== sv/vector_integer_elementwise_alu.sv =====
// ----------------------------------------------------------------------------
// vector_integer_elementwise_alu: integer lane of a vector element-wise ALU
//
//   channel   ports                                         dir
//   input     s_valid s_ready s_kind s_operand_a/b/c        in
//   result    m_valid m_ready m_result                      out
//   config    cfg_we cfg_wdata                              in
//
// Simple ops: one beat per cycle while the result does not stall, via queue and output register.
// Multiply: through the 32-bit partial products; no new beat leaves the queue until its result is loaded.
// Divide and remainder: through the one-bit-a-cycle divider; no new beat leaves the queue until its result is loaded.
// Reset is synchronous; a two-entry queue lets input and result stall apart.
// ----------------------------------------------------------------------------
module vector_integer_elementwise_alu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_kind,
    input  logic [63:0] s_operand_a,
    input  logic [63:0] s_operand_b,
    input  logic [63:0] s_operand_c,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result
);
    import veia_pkg::*;

    logic  q_valid, q_ready;
    item_t q_item;

    veia_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_operand_c (s_operand_c),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    veia_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Element-wise integer ALU testbench
// Streams directed operations at the 32-, 8- and 64-bit widths and random ones at random widths through the
// ALU with random idle gaps on both channels, predicts each result from the
// operands, and compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
import veia_pkg::*;

class alu_scoreboard;
    logic [63:0] expected_results[$];
    int          error_count;

    // note the prediction for an accepted operation beat
    function void note_operation(logic [63:0] predicted);
        expected_results.insert(expected_results.size(), predicted);
    endfunction

    // print one mismatch line and count it
    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // compare a result beat with the oldest prediction
    task check_result(logic [63:0] got);
        logic [63:0] want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with no operation pending", got));
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("result %h, predicted %h", got, want));
            end
        end
    endtask
endclass

module testbench;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_COUNT = 1150;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [4:0]  s_kind;
    logic [63:0] s_operand_a;
    logic [63:0] s_operand_b;
    logic [63:0] s_operand_c;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result;

    alu_scoreboard results_board;
    logic [1:0]    width_code;
    logic          stimulus_done;
    int            idle_cycles;

    vector_integer_elementwise_alu DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_operand_c (s_operand_c),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // compute the element result for one operation at the current width
    function automatic logic [63:0] alu_predict(logic [4:0] kind, logic [63:0] a,
                                                logic [63:0] b, logic [63:0] c,
                                                logic [1:0] ew);
        int unsigned bits;
        logic [63:0] mask, ua, ub, uc, r, q, rem;
        logic signed [63:0] sa, sb;
        bits = 8 << ew;
        mask = (ew == 2'd3) ? '1 : ((64'd1 << bits) - 64'd1);
        ua = a & mask;
        ub = b & mask;
        uc = c & mask;
        sa = (ua ^ (64'd1 << (bits - 1))) - (64'd1 << (bits - 1));
        sb = (ub ^ (64'd1 << (bits - 1))) - (64'd1 << (bits - 1));
        r = '0;
        case (kind)
            OP_ADD: r = ua + ub;
            OP_SUB: r = ua - ub;
            OP_MUL: r = ua * ub;
            OP_DIV: if (ub != 0) begin
                q = $unsigned(sa[63] ? -sa : sa) / $unsigned(sb[63] ? -sb : sb);
                r = (sa[63] != sb[63]) ? -q : q;
            end
            OP_SREM: if (ub != 0) begin
                rem = $unsigned(sa[63] ? -sa : sa) % $unsigned(sb[63] ? -sb : sb);
                r = sa[63] ? -rem : rem;
            end
            OP_UREM: if (ub != 0) r = ua % ub;
            OP_MAX:  r = (sb < sa) ? sa : sb;
            OP_MIN:  r = (sa < sb) ? sa : sb;
            OP_AND:  r = ua & ub;
            OP_OR:   r = ua | ub;
            OP_XOR:  r = ua ^ ub;
            OP_SHL:  r = (ub >= bits) ? '0 : ua << ub;
            OP_ASHR: r = (ub >= bits) ? {64{sa[63]}} : $unsigned(sa >>> ub);
            OP_NOT:  r = ~ua;
            OP_ABS:  r = sa[63] ? -sa : sa;
            OP_RELU: r = sa[63] ? '0 : ua;
            OP_EQ:   r = {63'd0, ua == ub};
            OP_NE:   r = {63'd0, ua != ub};
            OP_LT:   r = {63'd0, sa < sb};
            OP_GT:   r = {63'd0, sb < sa};
            OP_GE:   r = {63'd0, !(sa < sb)};
            OP_LE:   r = {63'd0, !(sb < sa)};
            OP_SEL:  r = (ua != 0) ? ub : uc;
            default: r = '0;
        endcase
        return r & mask;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // pick an operand biased toward lane edges
    function automatic logic [63:0] random_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return (64'd1 << $urandom_range(0, 63)) - 64'd1;
            4:       return {$urandom(), $urandom()} & 64'h7f;
            5:       return ~(64'd1 << $urandom_range(0, 63));
            default: return random_word();
        endcase
    endfunction

    // present one operation beat and hold it until accepted
    task automatic send_operation(logic [4:0] kind, logic [63:0] a,
                                  logic [63:0] b, logic [63:0] c);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_operand_a <= a;
        s_operand_b <= b;
        s_operand_c <= c;
        do @(posedge aclk); while (!s_ready);
        results_board.note_operation(alu_predict(kind, a, b, c, width_code));
    endtask

    // write the width register once the pipe has drained
    task automatic set_width(logic [1:0] code);
        s_valid <= 1'b0;
        while (results_board.expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        width_code = code;
    endtask

    task automatic run_directed();
        logic [63:0] edges[6];
        edges = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0080,
                  64'h0000_0000_8000_8000, 64'h7fff_ffff_ffff_ff7f};
        for (int k = 0; k <= 23; k++)
            send_operation(k[4:0], edges[k % 6], edges[(k + 2) % 6], edges[(k + 3) % 6]);
        // negative dividend (most negative at 8 bits) over minus one, and zero divisor
        send_operation(OP_DIV, 64'h8000_0000_8000_8080, '1, '0);
        send_operation(OP_DIV, 64'h8000_0000_8000_8080, '0, '0);
    endtask

    // accept results with random stalls
    initial begin
        int wait_cycles;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            wait_cycles = $urandom_range(0, 4);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_board.check_result(m_result);
        end
    end

    // stop a run that stops moving
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT && !stimulus_done) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [4:0] kind;
        results_board = new();
        stimulus_done = 1'b0;
        width_code  = EW_RESET;
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_kind      <= '0;
        s_operand_a <= '0;
        s_operand_b <= '0;
        s_operand_c <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        for (int w = 0; w < 4; w++) begin
            set_width(w[1:0]);
            if (w == 0 || w == 3) run_directed();
        end

        // random operations across widths, shift amounts mostly drawn from 0 to 70
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n % 150 == 0) set_width(2'($urandom_range(0, 3)));
            kind = 5'($urandom_range(0, 31));
            if (kind > 22 && $urandom_range(0, 3) != 0) kind = 5'($urandom_range(0, 22));
            if ((kind == OP_SHL || kind == OP_ASHR) && $urandom_range(0, 2) != 0)
                send_operation(kind, random_operand(), 64'($urandom_range(0, 70)),
                               random_word());
            else
                send_operation(kind, random_operand(), random_operand(), random_operand());
        end
        s_valid <= 1'b0;

        stimulus_done = 1'b1;
        idle_cycles   = 0;
        while (results_board.expected_results.size() != 0 && idle_cycles < IDLE_LIMIT)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (results_board.expected_results.size() == 0 && results_board.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
